>>> hdl/gripper_pickup_sequencer_top_defines.svh
// assertion macros for the gripper pickup sequencer
`ifndef GRIPPER_PICKUP_SEQUENCER_TOP_DEFINES_SVH
`define GRIPPER_PICKUP_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define GRIPSEQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GRIPSEQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/gripseq_pkg.sv
// shared types and constants for the gripper pickup sequencer
package gripseq_pkg;

   localparam int TIMER_BITS_DEF = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BEARING   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_TOLERANCE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_APPROACH_TIME_MS = 2'd2;

   localparam logic [15:0] TARGET_BEARING_RST   = 16'd0;
   localparam logic [13:0] ALIGN_TOLERANCE_RST  = 14'd313;
   localparam logic [15:0] APPROACH_TIME_MS_RST = 16'd3000;

   localparam int WAIT_MS   = 1000;
   localparam int VERIFY_MS = 2000;
   localparam int BACKUP_MS = 2250;

   localparam logic ACTION_STEP    = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   typedef enum logic [3:0] {
      PH_ALIGN     = 4'd0,
      PH_RECHECK   = 4'd1,
      PH_APPROACH  = 4'd2,
      PH_CLOSE     = 4'd3,
      PH_PRE_RAISE = 4'd4,
      PH_VERIFY    = 4'd5,
      PH_BACKUP    = 4'd6,
      PH_FAILED    = 4'd7,
      PH_SUCCESS   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      DRV_STOP = 2'd0,
      DRV_FWD  = 2'd1,
      DRV_REV  = 2'd2
   } drive_type;

   typedef enum logic [1:0] {
      TRN_NONE = 2'd0,
      TRN_POS  = 2'd1,
      TRN_NEG  = 2'd2
   } turn_type;

   typedef enum logic [1:0] {
      FNG_KEEP  = 2'd0,
      FNG_OPEN  = 2'd1,
      FNG_CLOSE = 2'd2
   } finger_type;

   typedef enum logic [1:0] {
      WR_KEEP  = 2'd0,
      WR_DOWN  = 2'd1,
      WR_UP    = 2'd2,
      WR_CARRY = 2'd3
   } wrist_type;

   typedef struct packed {
      logic [15:0] target_bearing;
      logic [13:0] align_tolerance;
      logic [15:0] approach_time_ms;
   } cfg_type;

   typedef struct packed {
      logic        action;
      logic [15:0] heading;
      logic [9:0]  elapsed_ms;
      logic        cube_held;
   } req_type;

   typedef struct packed {
      phase_type phase;
      logic      checked_once;
      drive_type drive;
      turn_type  turn;
      logic      success;
   } seq_type;

   typedef struct packed {
      phase_type  phase;
      drive_type  drive;
      turn_type   turn;
      finger_type finger;
      wrist_type  wrist;
      logic       picked_up;
   } rsp_type;

endpackage

>>> hdl/gripseq_csr.sv
// configuration registers of the gripper pickup sequencer
module gripseq_csr
   import gripseq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_BEARING:   cfg_in.target_bearing   = csr_wdata;
            CSR_ALIGN_TOLERANCE:  cfg_in.align_tolerance  = csr_wdata[13:0];
            CSR_APPROACH_TIME_MS: cfg_in.approach_time_ms = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_bearing   <= TARGET_BEARING_RST;
         cfg_ff.align_tolerance  <= ALIGN_TOLERANCE_RST;
         cfg_ff.approach_time_ms <= APPROACH_TIME_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/gripseq_step.sv
// one sequencer step: timer update, heading error and phase transition
module gripseq_step
   import gripseq_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  req_type                req,
   input  cfg_type                cfg,
   input  seq_type                seq,
   input  logic [TIMER_BITS-1:0]  timer,
   output seq_type                seq_nxt,
   output logic [TIMER_BITS-1:0]  timer_nxt,
   output rsp_type                rsp
);

   localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   logic [TIMER_BITS:0]   sum;
   logic [TIMER_BITS-1:0] tsat;
   logic [CMP_W-1:0]      tcmp;
   logic [15:0]           diff;
   logic signed [16:0]    err;
   logic signed [16:0]    tol;
   logic                  over;
   logic                  under;
   finger_type            finger;
   wrist_type             wrist;

   assign sum   = {1'b0, timer} + (TIMER_BITS + 1)'(req.elapsed_ms);
   assign tsat  = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
   assign tcmp  = CMP_W'(tsat);
   assign diff  = req.heading - cfg.target_bearing;
   assign err   = $signed({diff[15], diff});
   assign tol   = $signed({3'b000, cfg.align_tolerance});
   assign over  = err > tol;
   assign under = err < -tol;

   always_comb begin
      seq_nxt   = seq;
      timer_nxt = tsat;
      finger    = FNG_KEEP;
      wrist     = WR_KEEP;
      if (req.action == ACTION_RESTART) begin
         seq_nxt.phase        = PH_ALIGN;
         seq_nxt.checked_once = 1'b0;
         seq_nxt.drive        = DRV_STOP;
         seq_nxt.turn         = TRN_NONE;
         seq_nxt.success      = 1'b0;
         timer_nxt            = '0;
      end else begin
         case (seq.phase)
            PH_ALIGN: begin
               if (over) begin
                  seq_nxt.turn = TRN_POS;
               end else if (under) begin
                  seq_nxt.turn = TRN_NEG;
               end else begin
                  seq_nxt.turn  = TRN_NONE;
                  seq_nxt.phase = seq.checked_once ? PH_APPROACH : PH_RECHECK;
                  timer_nxt     = '0;
               end
               seq_nxt.drive = DRV_STOP;
               finger        = FNG_OPEN;
               wrist         = WR_DOWN;
            end
            PH_RECHECK: begin
               if (tcmp >= CMP_W'(WAIT_MS)) begin
                  seq_nxt.checked_once = 1'b1;
                  seq_nxt.phase        = PH_ALIGN;
               end
            end
            PH_APPROACH: begin
               seq_nxt.checked_once = 1'b0;
               seq_nxt.turn         = TRN_NONE;
               if (tcmp < CMP_W'(cfg.approach_time_ms)) begin
                  seq_nxt.drive = DRV_FWD;
               end else begin
                  seq_nxt.drive = DRV_STOP;
                  seq_nxt.phase = PH_CLOSE;
               end
            end
            PH_CLOSE: begin
               finger        = FNG_CLOSE;
               timer_nxt     = '0;
               seq_nxt.phase = PH_PRE_RAISE;
            end
            PH_PRE_RAISE: begin
               if (tcmp >= CMP_W'(WAIT_MS)) begin
                  wrist         = WR_UP;
                  seq_nxt.phase = PH_VERIFY;
               end
            end
            PH_VERIFY: begin
               if (tcmp < CMP_W'(VERIFY_MS)) begin
                  if (req.cube_held) begin
                     seq_nxt.phase = PH_SUCCESS;
                  end
               end else begin
                  timer_nxt     = '0;
                  seq_nxt.phase = PH_BACKUP;
               end
            end
            PH_BACKUP: begin
               if (tcmp < CMP_W'(BACKUP_MS)) begin
                  wrist         = WR_UP;
                  seq_nxt.drive = DRV_REV;
               end else begin
                  seq_nxt.drive = DRV_STOP;
                  seq_nxt.phase = PH_FAILED;
               end
            end
            PH_FAILED: ;
            PH_SUCCESS: begin
               wrist           = WR_CARRY;
               seq_nxt.success = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp.phase     = seq_nxt.phase;
      rsp.drive     = seq_nxt.drive;
      rsp.turn      = seq_nxt.turn;
      rsp.finger    = finger;
      rsp.wrist     = wrist;
      rsp.picked_up = seq_nxt.success;
   end

endmodule

>>> hdl/gripper_pickup_sequencer_top.sv
// top level of the gripper pickup sequencer
// Timed pickup sequencer for a robot gripper: each request transaction carries
// the heading, the milliseconds since the last transaction and the cube sensor,
// and yields exactly one response transaction with the phase and the drive,
// turn, finger and wrist commands. A new request is taken every clock cycle
// while the response register is free or draining; each request passes the
// input register, then one combinational step on the sequence state into the
// response register; the pace is held by that single step on the shared state.
// A stalled response keeps its successor in the input register, so a receiver
// that holds off stops further requests after one more transaction.
// Configuration writes are taken at any time but belong to an idle block.
`include "gripper_pickup_sequencer_top_defines.svh"

module gripper_pickup_sequencer_top
   import gripseq_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [15:0]           req_heading,
   input  logic [9:0]            req_elapsed_ms,
   input  logic                  req_cube_held,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_phase,
   output logic [1:0]            rsp_drive,
   output logic [1:0]            rsp_turn,
   output logic [1:0]            rsp_finger_cmd,
   output logic [1:0]            rsp_wrist_cmd,
   output logic                  rsp_picked_up,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type               cfg;
   req_type               req_ff, req_in;
   logic                  req_valid_ff, req_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   seq_type               seq_ff, seq_in, seq_step;
   logic [TIMER_BITS-1:0] timer_ff, timer_in, timer_step;
   rsp_type               rsp_step;
   logic                  req_take;
   logic                  adv;

   gripseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gripseq_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .req       (req_ff),
      .cfg       (cfg),
      .seq       (seq_ff),
      .timer     (timer_ff),
      .seq_nxt   (seq_step),
      .timer_nxt (timer_step),
      .rsp       (rsp_step)
   );

   // input stage advances when the response register is free or draining
   assign adv       = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || adv;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !adv);
      req_in       = req_ff;
      if (req_take) begin
         req_in.action     = req_action;
         req_in.heading    = req_heading;
         req_in.elapsed_ms = req_elapsed_ms;
         req_in.cube_held  = req_cube_held;
      end
      rsp_valid_in = adv || (rsp_valid_ff && !rsp_ready);
      rsp_in       = adv ? rsp_step : rsp_ff;
      seq_in       = adv ? seq_step : seq_ff;
      timer_in     = adv ? timer_step : timer_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         seq_ff.phase        <= PH_ALIGN;
         seq_ff.checked_once <= 1'b0;
         seq_ff.drive        <= DRV_STOP;
         seq_ff.turn         <= TRN_NONE;
         seq_ff.success      <= 1'b0;
         timer_ff            <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
         timer_ff     <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phase      = rsp_ff.phase;
   assign rsp_drive      = rsp_ff.drive;
   assign rsp_turn       = rsp_ff.turn;
   assign rsp_finger_cmd = rsp_ff.finger;
   assign rsp_wrist_cmd  = rsp_ff.wrist;
   assign rsp_picked_up  = rsp_ff.picked_up;

   `GRIPSEQ_ASSERT_IMP(a_picked_in_success, clock, reset, rsp_valid_ff && rsp_ff.picked_up, rsp_ff.phase == PH_SUCCESS, "picked_up outside success phase")
   `GRIPSEQ_ASSERT_IMP(a_fwd_in_approach, clock, reset, rsp_valid_ff && rsp_ff.drive == DRV_FWD, rsp_ff.phase == PH_APPROACH, "forward drive outside approach")
   `GRIPSEQ_ASSERT_IMP(a_rev_in_backup, clock, reset, rsp_valid_ff && rsp_ff.drive == DRV_REV, rsp_ff.phase == PH_BACKUP, "reverse drive outside back-up")
   `GRIPSEQ_ASSERT_IMP(a_close_to_raise, clock, reset, rsp_valid_ff && rsp_ff.finger == FNG_CLOSE, rsp_ff.phase == PH_PRE_RAISE, "finger close not followed by pre-raise")
   `GRIPSEQ_ASSERT_NXT(a_adv_gives_rsp, clock, reset, adv, rsp_valid_ff, "processed transaction without response")

endmodule
